/* hdl/cpuaf_pkg.sv */
// Shared types and constants for the ALU with flag byte.
`timescale 1ns / 1ps
`default_nettype none

package cpuaf_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned OpWidth   = 4;

  localparam int unsigned FLAG_S = 7;
  localparam int unsigned FLAG_Z = 6;
  localparam int unsigned FLAG_H = 4;
  localparam int unsigned FLAG_P = 2;
  localparam int unsigned FLAG_N = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD   = 4'd0,
    OP_ADC   = 4'd1,
    OP_SUB   = 4'd2,
    OP_SBC   = 4'd3,
    OP_AND   = 4'd4,
    OP_XOR   = 4'd5,
    OP_OR    = 4'd6,
    OP_CP    = 4'd7,
    OP_INC8  = 4'd8,
    OP_DEC8  = 4'd9,
    OP_ADD16 = 4'd10,
    OP_INC16 = 4'd11,
    OP_DEC16 = 4'd12
  } alu_op_t;

  typedef struct packed {
    logic [OpWidth-1:0]   req_type;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
    logic [ByteWidth-1:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic [ByteWidth-1:0] flags_out;
    logic                 write_back;
  } alu_res_t;

endpackage

`default_nettype wire

/* hdl/cpuaf_core.sv */
// Combinational ALU datapath: result, flag byte and write-back enable.
`timescale 1ns / 1ps
`default_nettype none

module cpuaf_core (
  input  cpuaf_pkg::alu_req_t req,
  output cpuaf_pkg::alu_res_t res
);
  import cpuaf_pkg::*;

  logic [ByteWidth-1:0] a8;
  logic [ByteWidth-1:0] b8;
  logic                 cin;
  logic                 use_cin;
  logic [ByteWidth:0]   add9;
  logic [4:0]           add_lo;
  logic [ByteWidth-1:0] add_r;
  logic [ByteWidth:0]   sub9;
  logic [4:0]           sub_lo;
  logic [ByteWidth-1:0] sub_r;
  logic [ByteWidth-1:0] inc_r;
  logic [ByteWidth-1:0] dec_r;
  logic [ByteWidth-1:0] and_r;
  logic [ByteWidth-1:0] xor_r;
  logic [ByteWidth-1:0] or_r;
  logic [DataWidth:0]   add17;
  logic [12:0]          add13;
  logic [ByteWidth-1:0] r8;
  logic [ByteWidth-1:0] f;

  assign a8      = req.operand_a[ByteWidth-1:0];
  assign b8      = req.operand_b[ByteWidth-1:0];
  assign use_cin = (alu_op_t'(req.req_type) == OP_ADC) || (alu_op_t'(req.req_type) == OP_SBC);
  assign cin     = use_cin & req.flags_in[FLAG_C];

  assign add9   = {1'b0, a8} + {1'b0, b8} + {{ByteWidth{1'b0}}, cin};
  assign add_lo = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign add_r  = add9[ByteWidth-1:0];
  assign sub9   = {1'b0, a8} - {1'b0, b8} - {{ByteWidth{1'b0}}, cin};
  assign sub_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
  assign sub_r  = sub9[ByteWidth-1:0];
  assign inc_r  = a8 + 8'd1;
  assign dec_r  = a8 - 8'd1;
  assign and_r  = a8 & b8;
  assign xor_r  = a8 ^ b8;
  assign or_r   = a8 | b8;
  assign add17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign add13  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};

  always_comb begin
    f              = req.flags_in;
    r8             = '0;
    res.result     = req.operand_a;
    res.write_back = 1'b1;
    unique case (alu_op_t'(req.req_type))
      OP_ADD, OP_ADC: begin
        r8        = add_r;
        f[FLAG_H] = add_lo[4];
        f[FLAG_P] = ((a8[7] ^ add_r[7]) & (b8[7] ^ add_r[7]));
        f[FLAG_C] = add9[ByteWidth];
        f[FLAG_N] = 1'b0;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8        = sub_r;
        f[FLAG_H] = sub_lo[4];
        f[FLAG_P] = ((a8[7] ^ b8[7]) & (a8[7] ^ sub_r[7]));
        f[FLAG_C] = sub9[ByteWidth];
        f[FLAG_N] = 1'b1;
        if (alu_op_t'(req.req_type) == OP_CP) begin
          res.write_back = 1'b0;
        end
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (alu_op_t'(req.req_type) == OP_AND) begin
          r8 = and_r;
        end else if (alu_op_t'(req.req_type) == OP_XOR) begin
          r8 = xor_r;
        end else begin
          r8 = or_r;
        end
        f[FLAG_H] = (alu_op_t'(req.req_type) == OP_AND);
        f[FLAG_P] = ~^r8;
        f[FLAG_N] = 1'b0;
        f[FLAG_C] = 1'b0;
      end
      OP_INC8: begin
        r8        = inc_r;
        f[FLAG_H] = (inc_r[3:0] == 4'h0);
        f[FLAG_P] = (inc_r == 8'h80);
        f[FLAG_N] = 1'b0;
      end
      OP_DEC8: begin
        r8        = dec_r;
        f[FLAG_H] = (dec_r[3:0] == 4'hF);
        f[FLAG_P] = (dec_r == 8'h7F);
        f[FLAG_N] = 1'b1;
      end
      OP_ADD16: begin
        res.result = add17[DataWidth-1:0];
        f[FLAG_H]  = add13[12];
        f[FLAG_C]  = add17[DataWidth];
        f[FLAG_N]  = 1'b0;
      end
      OP_INC16: begin
        res.result = req.operand_a + 16'd1;
      end
      OP_DEC16: begin
        res.result = req.operand_a - 16'd1;
      end
      default: begin
        res.write_back = 1'b0;
      end
    endcase
    if ((alu_op_t'(req.req_type) == OP_ADD) || (alu_op_t'(req.req_type) == OP_ADC) ||
        (alu_op_t'(req.req_type) == OP_SUB) || (alu_op_t'(req.req_type) == OP_SBC) ||
        (alu_op_t'(req.req_type) == OP_AND) || (alu_op_t'(req.req_type) == OP_XOR) ||
        (alu_op_t'(req.req_type) == OP_OR)  || (alu_op_t'(req.req_type) == OP_CP)  ||
        (alu_op_t'(req.req_type) == OP_INC8) || (alu_op_t'(req.req_type) == OP_DEC8)) begin
      res.result = {{(DataWidth-ByteWidth){1'b0}}, r8};
      f[FLAG_S]  = r8[7];
      f[FLAG_Z]  = (r8 == 8'h00);
    end
    res.flags_out = f;
  end

endmodule

`default_nettype wire

/* hdl/cpu_alu_with_flags_top.sv */
// Top level: input register, ALU datapath and result register.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------------
//   in_      | input     | in_valid / in_ready   | req_type, operand_a, operand_b, flags_in
//   out_     | output    | out_valid / out_ready | result, flags_out, write_back
//
// One transfer per cycle in and out while out_ready stays high; a request passes through the input
// register, the single ALU pass and the result register before out_valid rises, and a stall
// on out_ready can hold it between the two registers.
// rst_n clears both valid bits; payload registers are not reset.
// A stall on out_ready holds the result register; the input register still takes a new item
// while either stage is free.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [cpuaf_pkg::OpWidth-1:0]          in_req_type,
  input  wire logic [cpuaf_pkg::DataWidth-1:0]        in_operand_a,
  input  wire logic [cpuaf_pkg::DataWidth-1:0]        in_operand_b,
  input  wire logic [cpuaf_pkg::ByteWidth-1:0]        in_flags_in,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [cpuaf_pkg::DataWidth-1:0]             out_result,
  output logic [cpuaf_pkg::ByteWidth-1:0]             out_flags_out,
  output logic                                        out_write_back
);
  import cpuaf_pkg::*;

  logic     s1_v_r;
  alu_req_t s1_req_r;
  logic     s2_v_r;
  alu_res_t s2_res_r;
  alu_res_t s2_res_nxt;
  logic     s2_free;
  logic     s2_ld;

  assign s2_free  = !s2_v_r || out_ready;
  assign s2_ld    = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_req_r.req_type  <= in_req_type;
      s1_req_r.operand_a <= in_operand_a;
      s1_req_r.operand_b <= in_operand_b;
      s1_req_r.flags_in  <= in_flags_in;
    end
  end

  cpuaf_core u_core (
    .req (s1_req_r),
    .res (s2_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_ld) begin
      s2_res_r <= s2_res_nxt;
    end
  end

  assign out_valid      = s2_v_r;
  assign out_result     = s2_res_r.result;
  assign out_flags_out  = s2_res_r.flags_out;
  assign out_write_back = s2_res_r.write_back;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted transfer lost in input stage");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !s1_v_r) |=> !out_valid)
    else $error("result repeated after output transfer");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_free) |=> (s1_v_r && $stable(s1_req_r)))
    else $error("input stage changed while result stage stalled");

endmodule

`default_nettype wire
